// File: rtl/crc32mv_pkg.sv
// package with crc-32 constants, mode codes and fold functions
`default_nettype none

package crc32mv_pkg;

    localparam int unsigned CRC_W    = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned MODE_W   = 2;

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_ONES   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_TOPBIT = 32'h8000_0000;
    localparam int unsigned      BYTE_SHIFT = 24;

    typedef logic [CRC_W-1:0] crc_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_MODE       = 2'd0,
        CFG_INIT_VALUE = 2'd1,
        CFG_INVERT_OUT = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_addr_t;

    localparam logic [MODE_W-1:0] MODE_REFL_BYTE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MSB_BYTE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORD      = 2'd2;

    function automatic crc_t bit_reflect(input crc_t v);
        crc_t r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    localparam crc_t CRC_POLY_REFL = bit_reflect(CRC_POLY);

    // unrolled xor network, one step per data bit
    function automatic crc_t fold_refl_byte(input crc_t r_in, input logic [BYTE_W-1:0] b);
        crc_t r;
        r = r_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
        end
        return r;
    endfunction

    function automatic crc_t fold_msb_byte(input crc_t r_in, input logic [BYTE_W-1:0] b);
        crc_t r;
        r = r_in ^ ({{(CRC_W-BYTE_W){1'b0}}, b} << BYTE_SHIFT);
        for (int k = 0; k < BYTE_W; k++) begin
            r = ((r & CRC_TOPBIT) != '0) ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic crc_t fold_word(input crc_t r_in, input crc_t w);
        crc_t r;
        r = r_in;
        for (int k = 0; k < CRC_W; k++) begin
            r = ((r & CRC_TOPBIT) != '0) ? ((r << 1) ^ CRC_POLY) : (r << 1);
            if (w[CRC_W-1-k]) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/crc32_multi_variant_engine.sv
// crc-32 engine top level: reflected byte, msb-first byte and word modes
//
// input beats arrive on the s_ channel: s_tdata carries the message data
// (byte modes use bits 7..0, word mode all 32 bits) and s_tuser marks the
// first beat of a message, which reloads the configured initial value.
// every input beat yields exactly one output beat on the m_ channel with
// the running crc, complemented when invert_out is set.
// the fold is one xor network between the running crc register and the
// output register: a beat accepted at one edge shows on m_tdata after that
// edge, and a new beat is taken every cycle while the receiver does not stall.
// the output register is the only buffer: s_tready is high while it is
// empty or being drained, so a stalled receiver holds the input back after
// one beat and nothing is lost.
// configuration (mode, init_value, invert_out) is written through cfg_wr_en,
// cfg_addr and cfg_wdata; the user must write it only while the engine is
// idle, which the block itself does not enforce; unused indexes are ignored.
// synchronous active-low reset empties the output register and restores
// mode 0, init_value all ones, invert_out 1 and the crc register to all ones.
`default_nettype none

module crc32_multi_variant_engine
    import crc32mv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [CRC_W-1:0]  s_tdata,   // [31:0] data
    input  wire logic              s_tuser,   // [0] first
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [CRC_W-1:0]       m_tdata,   // [31:0] crc
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CRC_W-1:0]  cfg_wdata
);

    logic [MODE_W-1:0] mode_reg;
    crc_t              init_value_reg;
    logic              invert_out_reg;
    crc_t              crc_reg;
    crc_t              crc_next;
    crc_t              out_reg;
    logic              out_valid_reg;
    crc_t              crc_start;
    logic              in_beat;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign crc_start = s_tuser ? init_value_reg : crc_reg;

    always_comb begin
        if ((mode_reg & MODE_WORD) != '0) begin
            crc_next = fold_word(crc_start, s_tdata);
        end else if ((mode_reg & MODE_MSB_BYTE) != '0) begin
            crc_next = fold_msb_byte(crc_start, s_tdata[BYTE_W-1:0]);
        end else begin
            crc_next = fold_refl_byte(crc_start, s_tdata[BYTE_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_REFL_BYTE;
            init_value_reg <= CRC_ONES;
            invert_out_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_MODE:       mode_reg       <= cfg_wdata[MODE_W-1:0];
                CFG_INIT_VALUE: init_value_reg <= cfg_wdata;
                CFG_INVERT_OUT: invert_out_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_ONES;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_beat) begin
                crc_reg       <= crc_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            out_reg <= invert_out_reg ? ~crc_next : crc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/crc32mv_checker.sv
// port-level checker for the crc-32 engine and its bind
`default_nettype none

module crc32mv_checker
    import crc32mv_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [CRC_W-1:0] m_tdata
);

    // no output beat right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // every accepted input beat shows an output beat next cycle
    a_in_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("input beat produced no output beat");

    // empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output beat changed");

endmodule

bind crc32_multi_variant_engine crc32mv_checker u_crc32mv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: sim/tb_crc32_multi_variant_engine.sv
// testbench for the crc-32 engine: directed table then random message phases
`timescale 1ns / 100ps

module tb_crc32_multi_variant_engine;
    import crc32mv_pkg::*;

    localparam int unsigned  PHASES        = 9;
    localparam int unsigned  PHASE_BEATS   = 50;
    localparam int unsigned  IDLE_LIMIT    = 2000;
    localparam crc_t         POLY_LSB_FIRST = 32'hEDB8_8320;

    typedef struct {
        bit        is_cfg;
        cfg_addr_t addr;
        crc_t      value;
        logic      first;
        crc_t      data;
        bit        typed;
        crc_t      crc;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [CRC_W-1:0]  s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [CRC_W-1:0]  m_tdata;
    logic              cfg_wr_en;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CRC_W-1:0]  cfg_wdata;

    logic [MODE_W-1:0] cfg_mode;
    crc_t              cfg_init;
    logic              cfg_invert;
    crc_t              crc_state;
    crc_t              expected_crc[$];

    int err_cnt;
    int beats_in;
    int beats_out;
    int refl_beats;
    int msb_beats;
    int word_beats;
    int cfg_writes;
    int idle_cycles;
    bit calm_tx;
    bit calm_rx;

    crc32_multi_variant_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic crc_t fold_bits(input crc_t r_in, input int unsigned steps,
                                       input bit lsb_first);
        crc_t r;
        r = r_in;
        for (int k = 0; k < steps; k++) begin
            if (lsb_first) begin
                r = r[0] ? ((r >> 1) ^ POLY_LSB_FIRST) : (r >> 1);
            end else begin
                r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
            end
        end
        return r;
    endfunction

    function automatic crc_t crc_advance(input logic first, input crc_t data);
        crc_t r;
        r = first ? cfg_init : crc_state;
        if ((cfg_mode & MODE_WORD) != '0) begin
            r = fold_bits(r ^ data, CRC_W, 1'b0);
            word_beats++;
        end else if ((cfg_mode & MODE_MSB_BYTE) != '0) begin
            r = fold_bits(r ^ {data[BYTE_W-1:0], {(CRC_W-BYTE_W){1'b0}}}, BYTE_W, 1'b0);
            msb_beats++;
        end else begin
            r = fold_bits(r ^ {{(CRC_W-BYTE_W){1'b0}}, data[BYTE_W-1:0]}, BYTE_W, 1'b1);
            refl_beats++;
        end
        crc_state = r;
        return cfg_invert ? ~r : r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end else if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic stim_row_t row_cfg(input cfg_addr_t a, input crc_t v);
        stim_row_t row;
        row = '{1'b1, a, v, 1'b0, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic stim_row_t row_beat(input logic first, input crc_t data,
                                           input bit typed, input crc_t crc);
        stim_row_t row;
        row = '{1'b0, CFG_MODE, '0, first, data, typed, crc};
        return row;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_cnt++;
    endtask

    task automatic send_beat(input logic first, input crc_t data, input bit typed,
                             input crc_t crc);
        int   gap;
        crc_t pred;
        gap = calm_tx ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = first;
        s_tdata  = data;
        do @(posedge aclk); while (!s_tready);
        pred = crc_advance(first, data);
        expected_crc.push_back(typed ? crc : pred);
        beats_in++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_crc.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_addr_t a, input crc_t v);
        cfg_wr_en = 1'b1;
        cfg_addr  = a;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (a)
            CFG_MODE:       cfg_mode   = v[MODE_W-1:0];
            CFG_INIT_VALUE: cfg_init   = v;
            CFG_INVERT_OUT: cfg_invert = v[0];
            default:        ;
        endcase
        cfg_writes++;
    endtask

    // output checker
    always @(posedge aclk) begin
        crc_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (expected_crc.size() == 0) begin
                report_mismatch($sformatf("unexpected beat crc=%08h", m_tdata));
            end else begin
                want = expected_crc.pop_front();
                if (m_tdata !== want) begin
                    report_mismatch($sformatf("crc got %08h want %08h", m_tdata, want));
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("tb_crc32_multi_variant_engine: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver backpressure
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (!calm_rx) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin
        stim_row_t directed_rows[$];
        int        sent;
        int        msg_len;
        int        roll;
        bit        fresh;
        crc_t      data;
        crc_t      init_pick;

        err_cnt     = 0;
        beats_in    = 0;
        beats_out   = 0;
        refl_beats  = 0;
        msb_beats   = 0;
        word_beats  = 0;
        cfg_writes  = 0;
        calm_tx     = 1'b0;
        calm_rx     = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = CFG_MODE;
        cfg_wdata   = '0;
        cfg_mode    = MODE_REFL_BYTE;
        cfg_init    = CRC_ONES;
        cfg_invert  = 1'b1;
        crc_state   = CRC_ONES;

        directed_rows = '{
            // no first beat after reset: continue from the all-ones register
            row_beat(1'b0, 32'h0000_00FF, 1'b1, 32'hFF00_0000),
            row_beat(1'b1, 32'hFFFF_FF00, 1'b0, '0),
            row_beat(1'b0, 32'h1234_5678, 1'b0, '0),
            row_beat(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFF00_0000),
            row_cfg(CFG_MODE, crc_t'(MODE_MSB_BYTE)),
            row_beat(1'b1, 32'h0000_00FF, 1'b1, 32'h0000_00FF),
            row_beat(1'b0, 32'h0000_00A5, 1'b0, '0),
            row_beat(1'b0, 32'hFFFF_FF00, 1'b0, '0),
            row_cfg(CFG_INIT_VALUE, '0),
            row_beat(1'b1, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF),
            row_beat(1'b0, 32'h0000_0031, 1'b0, '0),
            row_cfg(CFG_INVERT_OUT, '0),
            row_beat(1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000),
            row_beat(1'b0, 32'h0000_00FF, 1'b0, '0),
            row_cfg(CFG_MODE, crc_t'(MODE_WORD)),
            row_beat(1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000),
            row_beat(1'b0, 32'hFFFF_FFFF, 1'b0, '0),
            row_beat(1'b0, 32'h8000_0000, 1'b0, '0),
            row_cfg(CFG_INIT_VALUE, CRC_ONES),
            row_cfg(CFG_INVERT_OUT, 32'h0000_0001),
            row_beat(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF),
            row_beat(1'b0, 32'h0000_0001, 1'b0, '0),
            // mode three behaves as word mode
            row_cfg(CFG_MODE, crc_t'(MODE_WORD | MODE_MSB_BYTE)),
            row_beat(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF),
            row_beat(1'b0, 32'hDEAD_BEEF, 1'b0, '0),
            row_cfg(CFG_UNUSED, 32'hFFFF_FFFF),
            // upper write bits are dropped
            row_cfg(CFG_MODE, {30'h3FFF_FFFF, MODE_REFL_BYTE}),
            row_beat(1'b1, 32'h0000_00FF, 1'b1, 32'hFF00_0000),
            row_beat(1'b0, 32'h0000_0000, 1'b0, '0),
            row_cfg(CFG_INVERT_OUT, 32'hFFFF_FFFE),
            row_beat(1'b1, 32'h0000_00FF, 1'b1, 32'h00FF_FFFF)
        };

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                wait_drained();
                write_reg(directed_rows[i].addr, directed_rows[i].value);
            end else begin
                send_beat(directed_rows[i].first, directed_rows[i].data,
                          directed_rows[i].typed, directed_rows[i].crc);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            calm_tx = ($urandom_range(0, 3) == 0);
            calm_rx = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 3);
            init_pick = (roll == 0) ? '0 : (roll == 1) ? CRC_ONES : crc_t'($urandom());
            write_reg(CFG_MODE, (crc_t'($urandom()) & ~crc_t'(3)) | $urandom_range(0, 3));
            write_reg(CFG_INIT_VALUE, init_pick);
            write_reg(CFG_INVERT_OUT, (crc_t'($urandom()) & ~crc_t'(1)) | $urandom_range(0, 1));
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_UNUSED, crc_t'($urandom()));
            end
            sent = 0;
            while (sent < PHASE_BEATS) begin
                msg_len = $urandom_range(1, 12);
                fresh   = ($urandom_range(0, 9) != 0);
                for (int k = 0; k < msg_len && sent < PHASE_BEATS; k++) begin
                    roll = $urandom_range(0, 15);
                    if (roll == 0) begin
                        data = '0;
                    end else if (roll == 1) begin
                        data = CRC_ONES;
                    end else if (roll == 2) begin
                        data = crc_t'(1) << $urandom_range(0, CRC_W - 1);
                    end else begin
                        data = crc_t'($urandom());
                    end
                    send_beat(fresh && (k == 0), data, 1'b0, '0);
                    sent++;
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("covered %0d input and %0d output beats over %0d register writes",
                 beats_in, beats_out, cfg_writes);
        $display("beats per fold: reflected byte %0d, msb-first byte %0d, word %0d",
                 refl_beats, msb_beats, word_beats);
        if (err_cnt == 0) begin
            $display("tb_crc32_multi_variant_engine: PASS");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("tb_crc32_multi_variant_engine: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/crc32mv_pkg.sv
rtl/crc32_multi_variant_engine.sv
rtl/crc32mv_checker.sv
sim/tb_crc32_multi_variant_engine.sv
